// ===== rtl/spr_pkg.sv =====
// Shared types and constants for the stream pattern replace block.
package spr_pkg;

    // Default sizes of the pattern and replacement stores.
    localparam int PATTERN_MAX_DEF = 8;
    localparam int REPLACE_MAX_DEF = 8;

    // Configuration port sizes.
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 64;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_PATTERN_BYTES = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_PATTERN_LEN   = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_REPLACE_BYTES = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_REPLACE_LEN   = 2'd3;

    // One input item.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
        logic       found_any;
    } t_out_item;

    // Per-cell control from the sequencer.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

endpackage

// ===== rtl/spr_cell.sv =====
// One cell of the held-byte row: stores a byte and compares it with its pattern byte.
module spr_cell (
    input  logic              i_clk,
    input  spr_pkg::t_cell_ctl i_ctl,
    input  logic [7:0]        i_data,
    input  logic [7:0]        i_next,
    input  logic [7:0]        i_pat_byte,
    output logic [7:0]        o_byte,
    output logic              o_hit
);

    logic [7:0] r_byte;

    // Load a new byte at the tail, or take the neighbor's byte on a shift.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_byte <= i_data;
        end else if (i_ctl.shift) begin
            r_byte <= i_next;
        end
    end

    assign o_byte = r_byte;
    assign o_hit  = (r_byte == i_pat_byte);

endmodule

// ===== rtl/stream_pattern_replace_top.sv =====
// Top level of the streaming find-and-replace block.
// A released byte passes the scan state and then the output register once its item is
// accepted; a replacement byte or a bare end marker passes the scan state, then the
// replace or end state, then the output register. A new item is taken only once the
// sequencer is idle; results leave byte by byte through the single output register.
// Reset (synchronous, active low) clears the sequencer, held count, match flag,
// output valid, and sets the pattern to the single byte 00 and the replacement to empty.
module stream_pattern_replace_top #(
    parameter int PATTERN_MAX = spr_pkg::PATTERN_MAX_DEF,
    parameter int REPLACE_MAX = spr_pkg::REPLACE_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input item channel
    input  logic                       i_valid,
    output logic                       o_stall,
    input  spr_pkg::t_in_item          i_item,
    // result item channel
    output logic                       o_valid,
    input  logic                       i_stall,
    output spr_pkg::t_out_item         o_item,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [spr_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [spr_pkg::CFG_DW-1:0] i_cfg_data
);

    localparam int CW = $clog2(PATTERN_MAX + 1);

    // Sequencer codes.
    localparam logic [1:0] ST_IDLE = 2'd0;  // wait for an item
    localparam logic [1:0] ST_SCAN = 2'd1;  // release, match check, flush
    localparam logic [1:0] ST_REPL = 2'd2;  // send replacement bytes
    localparam logic [1:0] ST_END  = 2'd3;  // send bare end marker

    // Configuration registers.
    logic [63:0] r_pat_bytes, n_pat_bytes;
    logic [3:0]  r_pat_len,   n_pat_len;
    logic [63:0] r_rep_bytes, n_rep_bytes;
    logic [3:0]  r_rep_len,   n_rep_len;

    // Sequencer state.
    logic [1:0]    r_state,    n_state;
    logic [CW-1:0] r_count,    n_count;
    logic          r_last,     n_last;
    logic          r_match,    n_match;
    logic [3:0]    r_repl_idx, n_repl_idx;

    // Output register.
    logic                r_out_valid, n_out_valid;
    spr_pkg::t_out_item  r_out,       n_out;

    // Cell row wiring.
    logic [7:0]  w_cell_byte [PATTERN_MAX];
    logic        w_hit       [PATTERN_MAX];
    logic        w_shift;
    logic        w_accept;
    logic        w_can_emit;
    logic        w_emit;
    logic        w_prefix;
    logic [3:0]  w_plen_full;
    logic [CW-1:0] w_plen;
    logic [3:0]  w_rlen;
    logic [3:0]  w_rlen_m1;
    spr_pkg::t_out_item w_emit_item;

    assign w_accept   = i_valid && !o_stall;
    assign w_can_emit = !r_out_valid || !i_stall;

    // Clamp the length registers into their legal ranges.
    always_comb begin
        if (r_pat_len == 4'd0) begin
            w_plen_full = 4'd1;
        end else if (r_pat_len > 4'(PATTERN_MAX)) begin
            w_plen_full = 4'(PATTERN_MAX);
        end else begin
            w_plen_full = r_pat_len;
        end
        if (r_rep_len > 4'(REPLACE_MAX)) begin
            w_rlen = 4'(REPLACE_MAX);
        end else begin
            w_rlen = r_rep_len;
        end
    end

    assign w_plen    = w_plen_full[CW-1:0];
    assign w_rlen_m1 = 4'(w_rlen - 4'd1);

    // Row of held-byte cells; cell 0 holds the oldest byte.
    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_MAX; gi++) begin : g_cell
            spr_pkg::t_cell_ctl w_ctl;
            logic [7:0]         w_next;

            assign w_ctl.load  = w_accept && (r_count == CW'(gi));
            assign w_ctl.shift = w_shift;

            if (gi == PATTERN_MAX - 1) begin : g_tail
                assign w_next = w_cell_byte[gi];
            end else begin : g_mid
                assign w_next = w_cell_byte[gi+1];
            end

            spr_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_data     (i_item.data_byte),
                .i_next     (w_next),
                .i_pat_byte (r_pat_bytes[gi*8 +: 8]),
                .o_byte     (w_cell_byte[gi]),
                .o_hit      (w_hit[gi])
            );
        end
    endgenerate

    // Held bytes form a pattern prefix when every cell in use hits.
    always_comb begin
        w_prefix = 1'b1;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if ((CW'(i) < r_count) && !w_hit[i]) begin
                w_prefix = 1'b0;
            end
        end
    end

    // Sequencer: one result item per cycle into the output register while it is not stalled.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_last      = r_last;
        n_match     = r_match;
        n_repl_idx  = r_repl_idx;
        n_pat_bytes = r_pat_bytes;
        n_pat_len   = r_pat_len;
        n_rep_bytes = r_rep_bytes;
        n_rep_len   = r_rep_len;
        w_shift     = 1'b0;
        w_emit      = 1'b0;
        w_emit_item = '0;

        case (r_state)
            ST_IDLE: begin
                // Append the new byte at the tail of the row.
                if (w_accept) begin
                    n_count = CW'(r_count + 1'b1);
                    n_last  = i_item.last_byte;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_count == '0) begin
                    // Everything released; the final item went out already if needed.
                    n_state = ST_IDLE;
                end else if (!w_prefix || r_last && (r_count != w_plen)) begin
                    // Release the oldest byte: either no prefix, or end-of-stream flush.
                    if (w_can_emit) begin
                        w_emit                = 1'b1;
                        w_emit_item.out_byte  = w_cell_byte[0];
                        w_emit_item.has_byte  = 1'b1;
                        w_emit_item.out_last  = r_last && (r_count == CW'(1));
                        w_emit_item.found_any = w_emit_item.out_last && r_match;
                        w_shift               = 1'b1;
                        n_count               = CW'(r_count - 1'b1);
                    end
                end else if (r_count == w_plen) begin
                    // Full match: drop the held bytes and send the replacement.
                    n_match    = 1'b1;
                    n_count    = '0;
                    n_repl_idx = '0;
                    if (w_rlen != 4'd0) begin
                        n_state = ST_REPL;
                    end else if (r_last) begin
                        n_state = ST_END;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    // Held bytes are a proper prefix: hold them for the next item.
                    n_state = ST_IDLE;
                end
            end
            ST_REPL: begin
                if (w_can_emit) begin
                    w_emit                = 1'b1;
                    w_emit_item.out_byte  = r_rep_bytes[{r_repl_idx[2:0], 3'b000} +: 8];
                    w_emit_item.has_byte  = 1'b1;
                    w_emit_item.out_last  = r_last && (r_repl_idx == w_rlen_m1);
                    w_emit_item.found_any = w_emit_item.out_last && r_match;
                    n_repl_idx            = 4'(r_repl_idx + 4'd1);
                    if (r_repl_idx == w_rlen_m1) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_END: begin
                // Bare end marker: nothing else came out of the final item.
                if (w_can_emit) begin
                    w_emit                = 1'b1;
                    w_emit_item.out_last  = 1'b1;
                    w_emit_item.found_any = r_match;
                    n_state               = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Clear the match flag once the stream's final item goes out.
        if (w_emit && w_emit_item.out_last) begin
            n_match = 1'b0;
        end

        // Configuration writes; a new pattern discards the held bytes.
        if (i_cfg_we) begin
            case (i_cfg_addr)
                spr_pkg::CFG_PATTERN_BYTES: begin
                    n_pat_bytes = i_cfg_data;
                    n_count     = '0;
                end
                spr_pkg::CFG_PATTERN_LEN: begin
                    n_pat_len = i_cfg_data[3:0];
                    n_count   = '0;
                end
                spr_pkg::CFG_REPLACE_BYTES: begin
                    n_rep_bytes = i_cfg_data;
                end
                spr_pkg::CFG_REPLACE_LEN: begin
                    n_rep_len = i_cfg_data[3:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: load a new item, or drop the current one once taken.
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_out       = w_emit_item;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_match     <= 1'b0;
            r_out_valid <= 1'b0;
            r_pat_bytes <= '0;
            r_pat_len   <= 4'd1;
            r_rep_bytes <= '0;
            r_rep_len   <= 4'd0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_match     <= n_match;
            r_out_valid <= n_out_valid;
            r_pat_bytes <= n_pat_bytes;
            r_pat_len   <= n_pat_len;
            r_rep_bytes <= n_rep_bytes;
            r_rep_len   <= n_rep_len;
        end
    end

    // Payload and per-item bookkeeping need no reset.
    always_ff @(posedge i_clk) begin
        r_last     <= n_last;
        r_repl_idx <= n_repl_idx;
        r_out      <= n_out;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

// ===== rtl/spr_checker.sv =====
// Port-level checks for the stream pattern replace block, bound to the top level.
module spr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input spr_pkg::t_out_item         o_item
);

    // No result item right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // One item at a time: an accepted item closes the input for the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input accepted on consecutive cycles");

    // The contains flag only rides on the final item of a stream.
    a_found_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.found_any |-> o_item.out_last)
        else $error("found_any set on a non-final item");

    // A bare marker is always the stream end and carries a zero byte.
    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.has_byte |-> o_item.out_last && (o_item.out_byte == 8'd0))
        else $error("bare marker not at stream end");

    // A stalled result item holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("stalled result item changed");

endmodule

bind stream_pattern_replace_top spr_checker u_spr_checker (.*);

// ===== tb/tb_stream_pattern_replace_top.sv =====
// Self-checking testbench for the streaming find-and-replace block.
module tb_stream_pattern_replace_top;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to let pass after the last awaited item: enough for the output latency
    // plus the trailing scan of the cell row, with room to spare.
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_ITEMS  = 220;
    // Length of the one long receiver hold that backs the block up.
    localparam int LONG_HOLD     = 400;

    // One row of the directed table: a register write or one input item,
    // optionally with its single result typed in by hand.
    typedef struct {
        bit                         is_write;
        logic [spr_pkg::CFG_AW-1:0] addr;
        logic [spr_pkg::CFG_DW-1:0] value;
        logic [7:0]                 data;
        bit                         last;
        bit                         typed;
        spr_pkg::t_out_item         want;
    } t_plan_row;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_valid    = 1'b0;
    logic                         o_stall;
    spr_pkg::t_in_item            i_item     = '0;
    logic                         o_valid;
    logic                         i_stall    = 1'b0;
    spr_pkg::t_out_item           o_item;
    logic                         i_cfg_we   = 1'b0;
    logic [spr_pkg::CFG_AW-1:0]   i_cfg_addr = '0;
    logic [spr_pkg::CFG_DW-1:0]   i_cfg_data = '0;

    // Predictor copy of the registers and of the held window.
    logic [63:0]         pat_bytes  = '0;
    logic [3:0]          pat_len    = 4'd1;
    logic [63:0]         rep_bytes  = '0;
    logic [3:0]          rep_len    = 4'd0;
    logic [7:0]          held_win [8];
    int                  held_cnt   = 0;
    bit                  stream_hit = 1'b0;

    // Result items still to come from the block, oldest first.
    spr_pkg::t_out_item  replaced_stream [$];
    t_plan_row           directed_rows [$];

    int                  mismatch_count = 0;
    int                  items_sent     = 0;
    int                  in_gap         = 0;
    int                  out_wait       = 0;
    int                  long_hold      = 0;
    int                  hold_req       = 0;
    int                  holds_seen     = 0;
    bit                  calm           = 1'b0;
    spr_pkg::t_out_item  head_item;

    stream_pattern_replace_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic spr_pkg::t_out_item mk_out(logic [7:0] b, logic h, logic l, logic f);
        spr_pkg::t_out_item r;
        r.out_byte  = b;
        r.has_byte  = h;
        r.out_last  = l;
        r.found_any = f;
        return r;
    endfunction

    // Pattern length as the block uses it: zero reads as one, above 8 saturates.
    function automatic int eff_plen();
        if (pat_len == 4'd0) return 1;
        if (pat_len > 4'd8) return 8;
        return int'(pat_len);
    endfunction

    // Idle or stall count for one item; zero throughout a calm stream.
    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 9));
    endfunction

    // Advance the find-and-replace state by one byte and queue the result
    // items it yields. Return how many were queued.
    function automatic int run_replacer(logic [7:0] b, logic last_in);
        int  plen;
        int  rlen;
        int  n0;
        int  i;
        bit  pre;
        plen = eff_plen();
        rlen = (rep_len > 4'd8) ? 8 : int'(rep_len);
        n0   = replaced_stream.size();
        if (held_cnt >= 8) held_cnt = 7;
        held_win[held_cnt] = b;
        held_cnt++;
        // Release the oldest held byte until the rest is a pattern prefix again.
        pre = 1'b0;
        while (!pre) begin
            pre = (held_cnt <= plen);
            for (i = 0; i < held_cnt; i++)
                if (held_win[i] != pat_bytes[8*i +: 8]) pre = 1'b0;
            if (!pre) begin
                replaced_stream.push_back(mk_out(held_win[0], 1'b1, 1'b0, 1'b0));
                for (i = 0; i < 7; i++) held_win[i] = held_win[i+1];
                held_cnt--;
            end
        end
        // Full match: swap in the replacement and drop the held run.
        if (held_cnt == plen) begin
            for (i = 0; i < rlen; i++)
                replaced_stream.push_back(mk_out(rep_bytes[8*i +: 8], 1'b1, 1'b0, 1'b0));
            held_cnt   = 0;
            stream_hit = 1'b1;
        end
        // End of stream: flush, mark the final item, and clear for the next stream.
        if (last_in) begin
            for (i = 0; i < held_cnt; i++)
                replaced_stream.push_back(mk_out(held_win[i], 1'b1, 1'b0, 1'b0));
            held_cnt = 0;
            if (replaced_stream.size() == n0)
                replaced_stream.push_back(mk_out(8'h00, 1'b0, 1'b0, 1'b0));
            replaced_stream[replaced_stream.size()-1].out_last  = 1'b1;
            replaced_stream[replaced_stream.size()-1].found_any = stream_hit;
            stream_hit = 1'b0;
        end
        return replaced_stream.size() - n0;
    endfunction

    task automatic flag_mismatch(string msg);
        mismatch_count++;
        $display("%0t ns  MISMATCH  %s", $realtime, msg);
    endtask

    function automatic void plan_write(logic [spr_pkg::CFG_AW-1:0] addr,
                                       logic [spr_pkg::CFG_DW-1:0] value);
        t_plan_row r;
        r          = '{default: '0};
        r.is_write = 1'b1;
        r.addr     = addr;
        r.value    = value;
        directed_rows.push_back(r);
    endfunction

    function automatic void plan_byte(logic [7:0] data, bit last, bit typed = 1'b0,
                                      spr_pkg::t_out_item want = '0);
        t_plan_row r;
        r       = '{default: '0};
        r.data  = data;
        r.last  = last;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    // Offer one item after this item's idle gap, hold it until accepted,
    // then predict. A hand-typed result replaces the predicted one.
    task automatic push_byte(logic [7:0] data, bit last, bit typed = 1'b0,
                             spr_pkg::t_out_item want = '0);
        int n;
        if (in_gap > 0) begin
            i_valid <= 1'b0;
            repeat (in_gap) @(posedge i_clk);
        end
        i_item  <= '{data_byte: data, last_byte: last};
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        n = run_replacer(data, last);
        if (typed) begin
            repeat (n) void'(replaced_stream.pop_back());
            replaced_stream.push_back(want);
        end
        in_gap = draw_wait();
        items_sent++;
    endtask

    // Drop valid, drain every awaited item, then let the block finish any
    // scan that yields nothing.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (replaced_stream.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [spr_pkg::CFG_AW-1:0] addr,
                             logic [spr_pkg::CFG_DW-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        // A pattern write throws away whatever run is held.
        case (addr)
            spr_pkg::CFG_PATTERN_BYTES: begin
                pat_bytes = value;
                held_cnt  = 0;
            end
            spr_pkg::CFG_PATTERN_LEN: begin
                pat_len  = value[3:0];
                held_cnt = 0;
            end
            spr_pkg::CFG_REPLACE_BYTES: rep_bytes = value;
            spr_pkg::CFG_REPLACE_LEN:   rep_len   = value[3:0];
            default: ;
        endcase
    endtask

    // Receiver: check each accepted item against the oldest expectation,
    // then draw how long to stall before taking the next one. A hold
    // request from the stimulus side stalls for a long stretch instead.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (replaced_stream.size() == 0) begin
                flag_mismatch($sformatf("result item %h with nothing awaited", o_item));
            end else begin
                head_item = replaced_stream.pop_front();
                if (o_item.out_byte !== head_item.out_byte)
                    flag_mismatch($sformatf("out_byte got %h want %h",
                                            o_item.out_byte, head_item.out_byte));
                if (o_item.has_byte !== head_item.has_byte)
                    flag_mismatch($sformatf("has_byte got %b want %b",
                                            o_item.has_byte, head_item.has_byte));
                if (o_item.out_last !== head_item.out_last)
                    flag_mismatch($sformatf("out_last got %b want %b",
                                            o_item.out_last, head_item.out_last));
                if (o_item.found_any !== head_item.found_any)
                    flag_mismatch($sformatf("found_any got %b want %b",
                                            o_item.found_any, head_item.found_any));
            end
            out_wait = draw_wait();
        end
        if (hold_req != holds_seen) begin
            holds_seen = hold_req;
            long_hold  = LONG_HOLD;
        end
        if (long_hold > 0) begin
            long_hold--;
            i_stall <= 1'b1;
        end else if (out_wait > 0) begin
            out_wait--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    initial begin
        logic [7:0]  alpha [4];
        logic [7:0]  text [$];
        logic [63:0] word;
        int          sent_goal;
        int          plen_now;
        int          cut;
        int          rewrite_at;
        int          k;
        int          j;
        bit          fresh;
        bit          hold_done;

        fresh     = 1'b1;
        hold_done = 1'b0;

        // Hold reset, then release it at a clock edge.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // After reset the pattern is the single byte 00 and the replacement
        // is empty: 00 is deleted, anything else passes.
        plan_byte(8'hFF, 1'b0, 1'b1, mk_out(8'hFF, 1'b1, 1'b0, 1'b0));
        plan_byte(8'h00, 1'b0);
        plan_byte(8'h01, 1'b1, 1'b1, mk_out(8'h01, 1'b1, 1'b1, 1'b1));
        // Last byte deleted: only a bare end marker comes out.
        plan_byte(8'h00, 1'b1, 1'b1, mk_out(8'h00, 1'b0, 1'b1, 1'b1));
        plan_byte(8'h80, 1'b1, 1'b1, mk_out(8'h80, 1'b1, 1'b1, 1'b0));

        // "abc" -> "XY"; upper bits of the length word must be ignored.
        plan_write(spr_pkg::CFG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
        plan_write(spr_pkg::CFG_PATTERN_LEN,   64'hFFFF_FFFF_FFFF_FFF3);
        plan_write(spr_pkg::CFG_REPLACE_BYTES, 64'h0000_0000_0000_5958);
        plan_write(spr_pkg::CFG_REPLACE_LEN,   64'd2);
        // Partial match that breaks, restart, full match, trailing byte.
        plan_byte("a", 1'b0);
        plan_byte("b", 1'b0);
        plan_byte("a", 1'b0);
        plan_byte("b", 1'b0);
        plan_byte("c", 1'b0);
        plan_byte("d", 1'b1);
        // Pattern rewrite mid-stream drops the held "ab" without emitting it.
        plan_byte("a", 1'b0);
        plan_byte("b", 1'b0);
        plan_write(spr_pkg::CFG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
        plan_byte("c", 1'b1);

        // Extremes: all-ones pattern, length words above the maximum saturate.
        plan_write(spr_pkg::CFG_PATTERN_BYTES, '1);
        plan_write(spr_pkg::CFG_PATTERN_LEN,   64'd15);
        plan_write(spr_pkg::CFG_REPLACE_BYTES, 64'h00FF_A55A_C33C_0FF0);
        plan_write(spr_pkg::CFG_REPLACE_LEN,   64'd12);
        repeat (8) plan_byte(8'hFF, 1'b0);
        // One held byte left at stream end gets flushed.
        plan_byte(8'hFF, 1'b1, 1'b1, mk_out(8'hFF, 1'b1, 1'b1, 1'b1));

        // Zero pattern length reads as one; zero replacement deletes.
        plan_write(spr_pkg::CFG_PATTERN_LEN, 64'd0);
        plan_write(spr_pkg::CFG_REPLACE_LEN, 64'd0);
        plan_byte(8'hFF, 1'b1, 1'b1, mk_out(8'h00, 1'b0, 1'b1, 1'b1));

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_write) begin
                wait_idle();
                write_reg(directed_rows[r].addr, directed_rows[r].value);
            end else begin
                push_byte(directed_rows[r].data, directed_rows[r].last,
                          directed_rows[r].typed, directed_rows[r].want);
            end
        end

        // Random streams, built mostly from the pattern and its prefixes so
        // that matches, broken matches and restarts come often.
        sent_goal = items_sent + RANDOM_ITEMS;
        while (items_sent < sent_goal) begin
            if (fresh || $urandom_range(0, 2) == 0) begin
                fresh = 1'b0;
                wait_idle();
                for (j = 0; j < 4; j++) alpha[j] = 8'($urandom);
                if ($urandom_range(0, 4) == 0) begin
                    word = {$urandom, $urandom};
                end else begin
                    for (j = 0; j < 8; j++) word[8*j +: 8] = alpha[$urandom_range(0, 3)];
                end
                write_reg(spr_pkg::CFG_PATTERN_BYTES, word);
                word = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
                word[3:0] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                        : 4'($urandom_range(1, 4));
                write_reg(spr_pkg::CFG_PATTERN_LEN, word);
                write_reg(spr_pkg::CFG_REPLACE_BYTES, {$urandom, $urandom});
                word = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : '0;
                word[3:0] = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                        : 4'($urandom_range(0, 8));
                write_reg(spr_pkg::CFG_REPLACE_LEN, word);
            end
            calm = ($urandom_range(0, 3) == 0);

            text.delete();
            plen_now = eff_plen();
            k = $urandom_range(1, 6);
            repeat (k) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        for (j = 0; j < plen_now; j++) text.push_back(pat_bytes[8*j +: 8]);
                    end
                    4, 5: begin
                        cut = $urandom_range(1, plen_now);
                        for (j = 0; j < cut; j++) text.push_back(pat_bytes[8*j +: 8]);
                    end
                    6, 7, 8: text.push_back(alpha[$urandom_range(0, 3)]);
                    default: text.push_back(8'($urandom));
                endcase
            end

            // Now and then rewrite a pattern register in the middle of a stream.
            rewrite_at = ($urandom_range(0, 7) == 0) ? int'($urandom_range(1, 8)) : -1;
            foreach (text[t]) begin
                if (t == rewrite_at) begin
                    wait_idle();
                    if ($urandom_range(0, 1) == 1)
                        write_reg(spr_pkg::CFG_PATTERN_BYTES, pat_bytes);
                    else
                        write_reg(spr_pkg::CFG_PATTERN_LEN, 64'($urandom_range(1, 8)));
                end
                // Halfway through, stall the receiver for a long stretch while
                // items keep coming, so the block backs up and stalls its input.
                if (!hold_done && items_sent >= sent_goal - RANDOM_ITEMS / 2) begin
                    hold_done = 1'b1;
                    hold_req++;
                end
                push_byte(text[t], t == text.size() - 1);
            end
        end

        wait_idle();
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Stop a hung run well past the slowest correct one.
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
